// File: hdl/crc16hx_pkg.sv
`timescale 1ns / 1ps

package crc16hx_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Index of the final, least significant digit of a result group.
  localparam logic [1:0] LAST_DIGIT = 2'd3;

  // A finished checksum handed from the CRC stage to the digit serializer.
  typedef struct packed {
    logic        valid;
    logic [15:0] word;
  } crc_load_t;

  // Folds one byte into the reflected register, bit 0 first.
  function automatic logic [15:0] fold_byte(input logic [15:0] reg_in,
                                            input logic [7:0]  byte_in);
    logic [15:0] r;
    logic        feedback;
    r = reg_in;
    for (int k = 0; k < 8; k++) begin
      feedback = byte_in[k] ^ r[0];
      r = {1'b0, r[15:1]};
      if (feedback) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Upper-case ASCII hex digit of one nibble.
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] code;
    if (nib < 4'd10) begin
      code = 7'd48 + {3'd0, nib};
    end else begin
      code = 7'd55 + {3'd0, nib};
    end
    return code;
  endfunction

endpackage

// File: hdl/crc16_hex_ascii.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_stall   data_byte[7:0], last_byte
// out      result     out_valid / out_stall hex_char[6:0], last_char
//
// Each accepted byte is folded into the CRC register in the cycle it is taken,
// so bytes flow at one per clock while in_stall is low. A byte marked last
// produces four output requests, registered in the serializer and drained at
// one per clock while out_stall is low. A one-deep holding slot lets a second
// message finish while digits drain; in_stall rises only while that slot is
// occupied. Reset (rst, synchronous) empties the output side and loads the register with 0xFFFF.

module crc16_hex_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] hex_char,
  output logic       last_char
);

  logic [15:0]           crc;
  logic [15:0]           crc_folded;
  logic                  in_take;
  logic                  ser_full;
  crc16hx_pkg::crc_load_t load;

  assign in_take    = in_valid && !in_stall;
  assign crc_folded = crc16hx_pkg::fold_byte(crc, data_byte);

  // The checksum register restarts after every message so that the next
  // byte begins a fresh computation.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= crc16hx_pkg::CRC_INIT;
    end else if (in_take) begin
      if (last_byte) begin
        crc <= crc16hx_pkg::CRC_INIT;
      end else begin
        crc <= crc_folded;
      end
    end
  end

  // The final value is sent complemented.
  assign load.valid = in_take && last_byte;
  assign load.word  = ~crc_folded;

  assign in_stall = ser_full;

  crc16hx_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .hex_char  (hex_char),
    .last_char (last_char),
    .full      (ser_full)
  );

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_take && last_byte) |=> (crc == crc16hx_pkg::CRC_INIT))
    else $error("register did not restart after the final byte");

endmodule

// File: hdl/crc16hx_ser.sv
`timescale 1ns / 1ps

module crc16hx_ser (
  input  logic                   clk,
  input  logic                   rst,
  input  crc16hx_pkg::crc_load_t load,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [6:0]             hex_char,
  output logic                   last_char,
  output logic                   full
);

  // Active word being shifted out, most significant nibble first.
  logic        ser_valid;
  logic [15:0] ser_word;
  logic [1:0]  ser_idx;

  // One-deep holding slot for a checksum that arrives while digits drain.
  logic        pend_valid;
  logic [15:0] pend_word;

  logic out_take;
  logic ser_done;

  assign out_take = ser_valid && !out_stall;
  assign ser_done = out_take && (ser_idx == crc16hx_pkg::LAST_DIGIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid  <= 1'b0;
      ser_idx    <= 2'd0;
      pend_valid <= 1'b0;
    end else begin
      if (!ser_valid || ser_done) begin
        if (pend_valid) begin
          ser_valid  <= 1'b1;
          ser_word   <= pend_word;
          ser_idx    <= 2'd0;
          pend_valid <= 1'b0;
        end else if (load.valid) begin
          ser_valid <= 1'b1;
          ser_word  <= load.word;
          ser_idx   <= 2'd0;
        end else begin
          ser_valid <= 1'b0;
        end
      end else begin
        if (out_take) begin
          ser_word <= {ser_word[11:0], 4'd0};
          ser_idx  <= ser_idx + 2'd1;
        end
        if (load.valid) begin
          pend_valid <= 1'b1;
          pend_word  <= load.word;
        end
      end
    end
  end

  assign out_valid = ser_valid;
  assign hex_char  = crc16hx_pkg::hex_digit(ser_word[15:12]);
  assign last_char = (ser_idx == crc16hx_pkg::LAST_DIGIT);
  assign full      = pend_valid;

  a_pend_needs_active: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ser_valid)
    else $error("holding slot filled while no word is active");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !load.valid)
    else $error("checksum delivered while the holding slot is full");

  a_pend_moves_up: assert property (@(posedge clk) disable iff (rst)
    (ser_done && pend_valid) |=> (ser_valid && ser_idx == 2'd0 && !pend_valid))
    else $error("held checksum not promoted after the last digit");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // The CRC starts from all ones and folds bytes in reflected order.
  localparam logic [15:0] SEED_VALUE     = 16'hFFFF;
  localparam logic [15:0] REFLECTED_POLY = 16'h8408;

  // Length of the run and of its quiet tail, counted in requests.
  localparam int ITEM_TARGET = 360;
  localparam int QUIET_ITEMS = 40;

  // The receiver holds off this long once, so that the holding slot fills and
  // the block has to stall its input.
  localparam int HOLD_CYCLES = 64;

  // Messages are numbered from zero after the directed part; the hold-off
  // starts with this message.
  localparam int HOLD_MESSAGE = 25;

  // Extra cycles after the last digit, long enough for a stray digit to show.
  localparam int DRAIN_CYCLES = 12;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       last_char;
  } digit_t;

  // One row of the directed table. When typed is set, the checksum word is
  // read off by hand and the digits are checked against it rather than the
  // running CRC.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [15:0] word;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] hex_char;
  logic       last_char;

  crc16_hex_ascii i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hex_char  (hex_char),
    .last_char (last_char)
  );

  // Digits still owed by the block, oldest first.
  digit_t      expected_digits[$];
  digit_t      want;
  logic [15:0] crc_state;

  int   error_count;
  int   items_sent;
  int   msg_count;
  int   msg_len;
  int   idle_cycles;
  logic [7:0] rand_byte;

  // Stimulus controls; quiet and hold_off_req are shared between the sender and the receiver.
  logic quiet;
  logic hold_off_req;
  logic tx_idle_on;

  // A single 0xFF byte leaves the register at 0x00FF, so the complement is
  // 0xFF00. The nine ASCII digits "123456789" give the standard X.25 check
  // value 0x906E. All other rows are checked through the running CRC.
  stim_row_t directed_rows [0:18] = '{
    '{8'hFF, 1'b1, 1'b1, 16'hFF00},
    '{8'h31, 1'b0, 1'b0, 16'h0000},
    '{8'h32, 1'b0, 1'b0, 16'h0000},
    '{8'h33, 1'b0, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 1'b0, 16'h0000},
    '{8'h35, 1'b0, 1'b0, 16'h0000},
    '{8'h36, 1'b0, 1'b0, 16'h0000},
    '{8'h37, 1'b0, 1'b0, 16'h0000},
    '{8'h38, 1'b0, 1'b0, 16'h0000},
    '{8'h39, 1'b1, 1'b1, 16'h906E},
    '{8'h00, 1'b1, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'h01, 1'b1, 1'b0, 16'h0000},
    '{8'hA5, 1'b0, 1'b0, 16'h0000},
    '{8'h5A, 1'b1, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 1'b1, 1'b0, 16'h0000}
  };

  // Byte-wide form of the reflected CRC: the byte is XORed into the low end
  // of the register and then eight single-bit shifts apply the polynomial.
  function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] r;
    r = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ REFLECTED_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [6:0] ascii_of_nibble(input logic [3:0] nib);
    return (nib > 4'd9) ? (7'h41 + 7'(nib - 4'd10)) : (7'h30 + 7'(nib));
  endfunction

  // A finished message owes four digits, most significant nibble first, and
  // only the fourth carries last_char.
  task automatic queue_digits(input logic [15:0] word);
    digit_t d;
    for (int n = 3; n >= 0; n--) begin
      d.hex_char  = ascii_of_nibble(word[4*n +: 4]);
      d.last_char = (n == 0);
      expected_digits.push_back(d);
    end
  endtask

  // Offers one request and holds it until the block takes it. The prediction
  // is made at the accepting edge, so the digits are queued before the first
  // of them can appear. An optional short gap follows, except while the
  // receiver holds off, since the input must keep pushing then.
  task automatic send_request(input logic [7:0]  data,
                              input logic        last,
                              input logic        typed,
                              input logic [15:0] typed_word);
    in_valid  <= 1'b1;
    data_byte <= data;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    crc_state = fold_crc_byte(crc_state, data);
    if (last) begin
      queue_digits(typed ? typed_word : ~crc_state);
      crc_state = SEED_VALUE;
    end
    items_sent++;
    if (tx_idle_on && !hold_off_req && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side. Short stall bursts come at random until the quiet tail.
  // When the sender asks for a hold-off, this process keeps out_stall high
  // for the HOLD_CYCLES hold-off period and then clears the request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checking and the hang watchdog. Outputs are sampled at the edge,
  // before any update that the edge itself causes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected digit: hex_char %0d last_char %0d", hex_char, last_char);
        error_count++;
      end else begin
        want = expected_digits.pop_front();
        if (hex_char !== want.hex_char) begin
          $error("hex_char: expected %0d, got %0d", want.hex_char, hex_char);
          error_count++;
        end
        if (last_char !== want.last_char) begin
          $error("last_char: expected %0d, got %0d", want.last_char, last_char);
          error_count++;
        end
      end
    end

    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Sender side: reset, the directed table, then random messages.
  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    data_byte    <= 8'h00;
    last_byte    <= 1'b0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    tx_idle_on   = 1'b1;
    crc_state    = SEED_VALUE;
    error_count  = 0;
    items_sent   = 0;
    msg_count    = 0;
    idle_cycles  = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].word);
    end

    // Mostly short messages, so that results come often, with an occasional
    // long one. Bytes lean toward all zeros and all ones now and then.
    while (items_sent < ITEM_TARGET) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                            : $urandom_range(1, 5);
      tx_idle_on = ($urandom_range(0, 2) != 0);
      if (msg_count == HOLD_MESSAGE) begin
        hold_off_req = 1'b1;
      end
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        quiet      = 1'b1;
        tx_idle_on = 1'b0;
      end
      for (int k = 0; k < msg_len; k++) begin
        case ($urandom_range(0, 7))
          0:       rand_byte = 8'h00;
          1:       rand_byte = 8'hFF;
          default: rand_byte = 8'($urandom_range(0, 255));
        endcase
        send_request(rand_byte, k == msg_len - 1, 1'b0, 16'h0000);
      end
      msg_count++;
    end

    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: crc16_hex_ascii.f
hdl/crc16hx_pkg.sv
hdl/crc16hx_ser.sv
hdl/crc16_hex_ascii.sv
dv/testbench.sv
